/* rtl/two_channel_value_noise_sample_macros.svh */
// assertion helpers for the value noise sampler checker
`ifndef TWO_CHANNEL_VALUE_NOISE_SAMPLE_MACROS_SVH
`define TWO_CHANNEL_VALUE_NOISE_SAMPLE_MACROS_SVH

// antecedent this cycle, consequent from the next cycle on
`define TCVN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) ante |=> cons) else $error(msg);

// antecedent and consequent start in the same cycle
`define TCVN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) ante |-> cons) else $error(msg);

`endif

/* rtl/tcvn_pkg.sv */
`default_nettype none
package tcvn_pkg;
  localparam int COORD_W   = 14;
  localparam int COEFF_W   = 6;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 8;
  localparam int OUT_W     = 19;
  localparam int REG_COUNT = 6;
  localparam int CFG_IDX_W = 3;
  localparam int OCT_W     = 3;
  localparam int ACC_W     = 21;
  localparam int FRAC_W    = 8;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_OCTAVE = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SAMPLE,
    OP_OCTAVE
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic [COEFF_W-1:0]        coeff;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic [VAL_W-1:0]          value;
  } entry_t;

  typedef logic [COEFF_W-1:0] coeff_arr_t [REG_COUNT];

  localparam logic [COEFF_W-1:0] COEFF_RESET [REG_COUNT] = '{
    6'd10, 6'd15, 6'd15, 6'd17, 6'd18, 6'd15
  };
endpackage
`default_nettype wire

/* rtl/tcvn_ram.sv */
`default_nettype none
module tcvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a_r,
  output logic [WIDTH-1:0]         rdata_b_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end
endmodule
`default_nettype wire

/* rtl/tcvn_front.sv */
`default_nettype none
module tcvn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [tcvn_pkg::COORD_W-1:0]  in_x_coord,
  input  logic [tcvn_pkg::COORD_W-1:0]  in_y_coord,
  input  logic [tcvn_pkg::COEFF_W-1:0]  in_coefficient,
  input  logic [tcvn_pkg::IDX_W-1:0]    in_entry_row,
  input  logic [tcvn_pkg::IDX_W-1:0]    in_entry_col,
  input  logic signed [tcvn_pkg::VAL_W-1:0] in_entry_value,
  input  logic                          pop,
  output logic                          head_valid,
  output tcvn_pkg::entry_t              head
);
  import tcvn_pkg::*;

  entry_t     q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;
  logic       known;
  logic       push;
  entry_t     incoming;

  always_comb begin
    incoming.x     = in_x_coord;
    incoming.y     = in_y_coord;
    incoming.coeff = in_coefficient;
    incoming.row   = in_entry_row;
    incoming.col   = in_entry_col;
    incoming.value = in_entry_value;
    known          = 1'b1;
    unique case (in_kind)
      KIND_WRITE:  incoming.op = OP_WRITE;
      KIND_SAMPLE: incoming.op = OP_SAMPLE;
      KIND_OCTAVE: incoming.op = OP_OCTAVE;
      default: begin
        // unused kind is taken and dropped
        incoming.op = OP_WRITE;
        known       = 1'b0;
      end
    endcase
  end

  assign busy       = (count_r == 2'd2);
  assign push       = start && !busy && known;
  assign head_valid = (count_r != 2'd0);
  assign head       = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= incoming;
    end
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* rtl/tcvn_back.sv */
`default_nettype none
module tcvn_back #(
  parameter int LATTICE_BITS = 6,
  parameter int OCTAVE_COUNT = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  tcvn_pkg::entry_t             head,
  input  tcvn_pkg::coeff_arr_t         coeffs,
  output logic                         pop,
  output logic                         out_strobe,
  output logic [tcvn_pkg::OUT_W-1:0]   out_noise_value
);
  import tcvn_pkg::*;

  localparam int LB     = LATTICE_BITS;
  localparam int CW     = LB + FRAC_W;
  localparam int SW     = COORD_W + FRAC_W;
  localparam int BAW    = 2 * LB - 2;
  localparam int BDEPTH = 1 << BAW;

  // issue stage: one octave (eight table reads over four banks) per cycle
  logic [OCT_W-1:0] oct_r, oct_nxt;
  logic             is_oct, last0, issue, wr;
  logic [OCT_W-1:0] sh;
  logic [SW-1:0]    xs, ys;
  logic [CW-1:0]    sx, sy;
  logic [LB-1:0]    ix, iy, iyb;
  logic [COEFF_W-1:0] c0;
  logic [BAW-1:0]   ra [4];
  logic [BAW-1:0]   rb [4];
  logic [LB-1:0]    wrow, wcol;
  logic [BAW-1:0]   waddr;
  logic [1:0]       wbank;
  logic [VAL_W-1:0] da [4];
  logic [VAL_W-1:0] db [4];

  assign is_oct = (head.op == OP_OCTAVE);
  assign last0  = !is_oct || (oct_r == OCT_W'(OCTAVE_COUNT - 1));
  assign issue  = head_valid && (head.op != OP_WRITE);
  assign wr     = head_valid && (head.op == OP_WRITE);
  assign pop    = head_valid && last0;
  assign sh     = oct_r + OCT_W'(2);

  always_comb begin
    oct_nxt = oct_r;
    if (head_valid && is_oct) begin
      oct_nxt = last0 ? '0 : oct_r + OCT_W'(1);
    end
  end

  always_comb begin
    xs  = is_oct ? ({head.x, {FRAC_W{1'b0}}} >> sh) : SW'(head.x);
    ys  = is_oct ? ({head.y, {FRAC_W{1'b0}}} >> sh) : SW'(head.y);
    sx  = xs[CW-1:0];
    sy  = ys[CW-1:0];
    ix  = sx[CW-1:FRAC_W];
    iy  = sy[CW-1:FRAC_W];
    iyb = iy + LB'(10);
    c0  = is_oct ? coeffs[oct_r] : head.coeff;
  end

  // bank by row and column parity: each bank holds one corner of each cell
  always_comb begin
    logic [LB-1:0] rowa, rowb, colb;
    for (int b = 0; b < 4; b++) begin
      rowa  = (iy[0] == b[1])  ? iy  : iy + LB'(1);
      rowb  = (iyb[0] == b[1]) ? iyb : iyb + LB'(1);
      colb  = (ix[0] == b[0])  ? ix  : ix + LB'(1);
      ra[b] = {rowa[LB-1:1], colb[LB-1:1]};
      rb[b] = {rowb[LB-1:1], colb[LB-1:1]};
    end
  end

  assign wrow  = LB'(head.row);
  assign wcol  = LB'(head.col);
  assign wbank = {wrow[0], wcol[0]};
  assign waddr = {wrow[LB-1:1], wcol[LB-1:1]};

  for (genvar g = 0; g < 4; g++) begin : g_bank
    tcvn_ram #(.WIDTH(VAL_W), .DEPTH(BDEPTH)) u_ram (
      .clk       (clk),
      .we        (wr && (wbank == 2'(g))),
      .waddr     (waddr),
      .wdata     (head.value),
      .raddr_a   (ra[g]),
      .raddr_b   (rb[g]),
      .rdata_a_r (da[g]),
      .rdata_b_r (db[g])
    );
  end

  // interpolation pipeline, all sums modulo 2^21: only bits 20..13 survive
  logic               v1_r, v2_r, v3_r, v4_r;
  logic               first1_r, first2_r, first3_r, first4_r;
  logic               last1_r, last2_r, last3_r, last4_r;
  logic [FRAC_W-1:0]  fx1_r, fy1_r, fy2_r;
  logic [COEFF_W-1:0] c1_r, c2_r, c3_r;
  logic               pr1_r, pc1_r;
  logic [ACC_W-1:0]   ta2_r, ba2_r, tb2_r, bb2_r, ya3_r, yb3_r;
  logic [15:0]        pack4_r;
  logic [OUT_W-1:0]   acc_r, acc_nxt;
  logic               out_strobe_r;
  logic [OUT_W-1:0]   out_noise_value_r;

  function automatic logic [ACC_W-1:0] sext(input logic [VAL_W-1:0] v);
    return {{(ACC_W - VAL_W){v[VAL_W-1]}}, v};
  endfunction

  logic [ACC_W-1:0] wfx, wfy, fxe, fye;
  logic [ACC_W-1:0] ta, ba, tb, bb, ya, yb, pa, pb;
  logic [1:0]       k0, k1, k2, k3;

  always_comb begin
    k0  = {pr1_r, pc1_r};
    k1  = {pr1_r, ~pc1_r};
    k2  = {~pr1_r, pc1_r};
    k3  = {~pr1_r, ~pc1_r};
    fxe = ACC_W'(fx1_r);
    wfx = ACC_W'(256) - fxe;
    ta  = sext(da[k0]) * wfx + sext(da[k1]) * fxe;
    ba  = sext(da[k2]) * wfx + sext(da[k3]) * fxe;
    tb  = sext(db[k0]) * wfx + sext(db[k1]) * fxe;
    bb  = sext(db[k2]) * wfx + sext(db[k3]) * fxe;
    fye = ACC_W'(fy2_r);
    wfy = ACC_W'(256) - fye;
    ya  = ta2_r * wfy + ba2_r * fye;
    yb  = tb2_r * wfy + bb2_r * fye;
    pa  = ya3_r * ACC_W'(c3_r);
    pb  = yb3_r * ACC_W'(c3_r);
    acc_nxt = (first4_r ? '0 : acc_r) + OUT_W'(pack4_r);
  end

  always_ff @(posedge clk) begin
    fx1_r    <= sx[FRAC_W-1:0];
    fy1_r    <= sy[FRAC_W-1:0];
    c1_r     <= c0;
    pr1_r    <= iy[0];
    pc1_r    <= ix[0];
    first1_r <= !is_oct || (oct_r == '0);
    last1_r  <= last0;
    ta2_r    <= ta;
    ba2_r    <= ba;
    tb2_r    <= tb;
    bb2_r    <= bb;
    fy2_r    <= fy1_r;
    c2_r     <= c1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    ya3_r    <= ya;
    yb3_r    <= yb;
    c3_r     <= c2_r;
    first3_r <= first2_r;
    last3_r  <= last2_r;
    pack4_r  <= {pa[ACC_W-1:ACC_W-8], pb[ACC_W-1:ACC_W-8]};
    first4_r <= first3_r;
    last4_r  <= last3_r;
    if (v4_r) begin
      acc_r <= acc_nxt;
    end
    out_noise_value_r <= acc_nxt;
    if (!rst_n) begin
      oct_r        <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      oct_r        <= oct_nxt;
      v1_r         <= issue;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      out_strobe_r <= v4_r && last4_r;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_noise_value = out_noise_value_r;
endmodule
`default_nettype wire

/* rtl/two_channel_value_noise_sample.sv */
`default_nettype none
// two-channel bilinear value noise over a banked signed 8-bit lattice.
// input: a request is taken at a rising edge with start high and busy low.
//   kind 0 writes one lattice entry, kind 1 asks for one packed sample
//   (two channels ten rows apart), kind 2 asks for the sum of OCTAVE_COUNT
//   samples, octave i using octave_coeff_i; kind 3 is taken and dropped.
// requests pass a two-entry queue to the sequencer; busy is high while it
//   is full.
// output: out_strobe marks out_noise_value for one cycle; the receiver has
//   no way to hold it, so nothing ever waits on the output side.
// path: a queued sample is read from the banks, passes the interpolation
//   pipeline and strobes; an octave sum strobes after its last octave.
// sequencing: writes and samples pass one at a time, an octave sum octave by
//   octave; the four parity banks give the eight corner reads of one octave
//   per cycle, and the next request starts while older ones are in flight.
// reset: coefficient registers take their defaults, queue and pipeline
//   empty; the lattice is undefined until written.
// cfg_we writes octave_coeff_<cfg_index>; indexes past five are ignored.
module two_channel_value_noise_sample #(
  parameter int LATTICE_BITS = 6,
  parameter int OCTAVE_COUNT = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic [tcvn_pkg::COORD_W-1:0]      in_x_coord,
  input  logic [tcvn_pkg::COORD_W-1:0]      in_y_coord,
  input  logic [tcvn_pkg::COEFF_W-1:0]      in_coefficient,
  input  logic [tcvn_pkg::IDX_W-1:0]        in_entry_row,
  input  logic [tcvn_pkg::IDX_W-1:0]        in_entry_col,
  input  logic signed [tcvn_pkg::VAL_W-1:0] in_entry_value,
  output logic                              out_strobe,
  output logic [tcvn_pkg::OUT_W-1:0]        out_noise_value,
  input  logic                              cfg_we,
  input  logic [tcvn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcvn_pkg::COEFF_W-1:0]      cfg_wdata
);
  import tcvn_pkg::*;

  coeff_arr_t coeff_r;
  logic       head_valid, pop;
  entry_t     head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        coeff_r[i] <= COEFF_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
      coeff_r[cfg_index] <= cfg_wdata;
    end
  end

  tcvn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_coefficient (in_coefficient),
    .in_entry_row   (in_entry_row),
    .in_entry_col   (in_entry_col),
    .in_entry_value (in_entry_value),
    .pop            (pop),
    .head_valid     (head_valid),
    .head           (head)
  );

  tcvn_back #(
    .LATTICE_BITS (LATTICE_BITS),
    .OCTAVE_COUNT (OCTAVE_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .coeffs          (coeff_r),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_noise_value (out_noise_value)
  );
endmodule
`default_nettype wire

/* rtl/tcvn_checker.sv */
`default_nettype none
`include "two_channel_value_noise_sample_macros.svh"
module tcvn_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);
  // reset empties the queue and the pipeline
  `TCVN_ASSERT_NEXT(a_rst_strobe, !rst_n, !out_strobe, "strobe right after reset")
  `TCVN_ASSERT_NEXT(a_rst_busy, !rst_n, !busy, "busy right after reset")
  // no result can reach the output sooner than the pipeline depth
  `TCVN_ASSERT_NOW(a_rst_quiet, !rst_n, ##6 !out_strobe, "result too soon after reset")
  // the queue only fills on a request
  `TCVN_ASSERT_NOW(a_busy_rise, $rose(busy), $past(start), "busy without a request")
endmodule

bind two_channel_value_noise_sample tcvn_checker u_tcvn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);
`default_nettype wire
